// File: rtl/s2a_pkg.sv
// ----------------------------------------------------------------------------
// s2a_pkg
// Types, constants and scancode tables for the scancode to ASCII FIFO unit.
// ----------------------------------------------------------------------------
package s2a_pkg;

  localparam int FIFO_DEPTH = 128;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int ENTRY_W    = 9;

  localparam logic       REQ_SCAN   = 1'b0;
  localparam logic       REQ_POP    = 1'b1;

  localparam logic [7:0] SC_PREFIX  = 8'hE0;
  localparam logic [6:0] SC_LSHIFT  = 7'h2A;
  localparam logic [6:0] SC_RSHIFT  = 7'h36;
  localparam logic [6:0] SC_CAPS    = 7'h3A;

  localparam logic [7:0] NAV_UP     = 8'd0;
  localparam logic [7:0] NAV_DOWN   = 8'd1;
  localparam logic [7:0] NAV_LEFT   = 8'd2;
  localparam logic [7:0] NAV_RIGHT  = 8'd3;
  localparam logic [7:0] NAV_HOME   = 8'd4;
  localparam logic [7:0] NAV_END    = 8'd5;
  localparam logic [7:0] NAV_DEL    = 8'd6;
  localparam logic [7:0] NAV_PGUP   = 8'd7;
  localparam logic [7:0] NAV_PGDN   = 8'd8;

  typedef struct packed {
    logic       req_type;
    logic [7:0] scan_byte;
  } in_item_t;

  typedef struct packed {
    logic       char_valid;
    logic       is_special;
    logic [7:0] char_code;
  } out_item_t;

  typedef struct packed {
    logic       is_special;
    logic [7:0] char_code;
  } fifo_entry_t;

  typedef struct packed {
    logic        shift_held;
    logic        caps_on;
    logic        prefix_seen;
    logic        put;
    fifo_entry_t entry;
  } xlate_t;

  function automatic logic [7:0] plain_char(input logic [6:0] code);
    logic [7:0] ch;
    case (code)
      7'h01: ch = 8'd27;
      7'h02: ch = "1";
      7'h03: ch = "2";
      7'h04: ch = "3";
      7'h05: ch = "4";
      7'h06: ch = "5";
      7'h07: ch = "6";
      7'h08: ch = "7";
      7'h09: ch = "8";
      7'h0A: ch = "9";
      7'h0B: ch = "0";
      7'h0C: ch = "-";
      7'h0D: ch = "=";
      7'h0E: ch = 8'd8;
      7'h0F: ch = 8'd9;
      7'h10: ch = "q";
      7'h11: ch = "w";
      7'h12: ch = "e";
      7'h13: ch = "r";
      7'h14: ch = "t";
      7'h15: ch = "y";
      7'h16: ch = "u";
      7'h17: ch = "i";
      7'h18: ch = "o";
      7'h19: ch = "p";
      7'h1A: ch = 8'h5B;
      7'h1B: ch = 8'h5D;
      7'h1C: ch = 8'd10;
      7'h1E: ch = "a";
      7'h1F: ch = "s";
      7'h20: ch = "d";
      7'h21: ch = "f";
      7'h22: ch = "g";
      7'h23: ch = "h";
      7'h24: ch = "j";
      7'h25: ch = "k";
      7'h26: ch = "l";
      7'h27: ch = 8'h3B;
      7'h28: ch = 8'h27;
      7'h29: ch = 8'h60;
      7'h2B: ch = 8'h5C;
      7'h2C: ch = "z";
      7'h2D: ch = "x";
      7'h2E: ch = "c";
      7'h2F: ch = "v";
      7'h30: ch = "b";
      7'h31: ch = "n";
      7'h32: ch = "m";
      7'h33: ch = 8'h2C;
      7'h34: ch = 8'h2E;
      7'h35: ch = 8'h2F;
      7'h37: ch = 8'h2A;
      7'h39: ch = 8'h20;
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] shift_char(input logic [6:0] code);
    logic [7:0] ch;
    case (code)
      7'h02: ch = 8'h21;
      7'h03: ch = 8'h40;
      7'h04: ch = 8'h23;
      7'h05: ch = 8'h24;
      7'h06: ch = 8'h25;
      7'h07: ch = 8'h5E;
      7'h08: ch = 8'h26;
      7'h09: ch = 8'h2A;
      7'h0A: ch = 8'h28;
      7'h0B: ch = 8'h29;
      7'h0C: ch = 8'h5F;
      7'h0D: ch = 8'h2B;
      7'h1A: ch = 8'h7B;
      7'h1B: ch = 8'h7D;
      7'h27: ch = 8'h3A;
      7'h28: ch = 8'h22;
      7'h29: ch = 8'h7E;
      7'h2B: ch = 8'h7C;
      7'h33: ch = 8'h3C;
      7'h34: ch = 8'h3E;
      7'h35: ch = 8'h3F;
      default: begin
        ch = plain_char(code);
        if (ch >= "a" && ch <= "z") begin
          ch = ch ^ 8'h20;
        end
      end
    endcase
    return ch;
  endfunction

endpackage

// File: rtl/s2a_ram.sv
// ----------------------------------------------------------------------------
// s2a_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module s2a_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/s2a_xlate.sv
// ----------------------------------------------------------------------------
// s2a_xlate
// Scancode decoder: next modifier flags and the FIFO entry for one byte.
// ----------------------------------------------------------------------------
module s2a_xlate import s2a_pkg::*; (
  input  logic [7:0] scan_byte,
  input  logic       shift_held,
  input  logic       caps_on,
  input  logic       prefix_seen,
  output xlate_t     xlate
);

  logic [6:0] code;
  logic [7:0] ch;
  logic [7:0] nav;
  logic       nav_hit;

  assign code = scan_byte[6:0];

  always_comb begin
    nav_hit = 1'b1;
    case (code)
      7'h48:   nav = NAV_UP;
      7'h50:   nav = NAV_DOWN;
      7'h4B:   nav = NAV_LEFT;
      7'h4D:   nav = NAV_RIGHT;
      7'h47:   nav = NAV_HOME;
      7'h4F:   nav = NAV_END;
      7'h53:   nav = NAV_DEL;
      7'h49:   nav = NAV_PGUP;
      7'h51:   nav = NAV_PGDN;
      default: begin
        nav     = 8'd0;
        nav_hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    ch = shift_held ? shift_char(code) : plain_char(code);
    if (caps_on && ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z"))) begin
      ch = ch ^ 8'h20;
    end
  end

  always_comb begin
    xlate.shift_held = shift_held;
    xlate.caps_on    = caps_on;
    xlate.prefix_seen = prefix_seen;
    xlate.put        = 1'b0;
    xlate.entry      = '{is_special: 1'b0, char_code: ch};
    if (scan_byte == SC_PREFIX) begin
      xlate.prefix_seen = 1'b1;
    end else if (scan_byte[7]) begin
      xlate.prefix_seen = 1'b0;
      if (!prefix_seen && (code == SC_LSHIFT || code == SC_RSHIFT)) begin
        xlate.shift_held = 1'b0;
      end
    end else if (prefix_seen) begin
      xlate.prefix_seen = 1'b0;
      xlate.put         = nav_hit;
      xlate.entry       = '{is_special: 1'b1, char_code: nav};
    end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
      xlate.shift_held = 1'b1;
    end else if (code == SC_CAPS) begin
      xlate.caps_on = !caps_on;
    end else begin
      xlate.put = (ch != 8'd0);
    end
  end

endmodule

// File: rtl/scancode_to_ascii_fifo_unit.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_unit
// PS/2 set-1 scancode translator feeding a character ring FIFO with pops.
// ----------------------------------------------------------------------------
//   port group   direction  payload      handshake
//   in_*         into unit  in_item_t    in_valid / in_stall
//   out_*        from unit  out_item_t   out_valid / out_stall
//
// One transaction per cycle is taken unless the input stalls. A scancode
// updates the flags and may write the FIFO RAM in the cycle it is taken and
// gives no result. A pop reads the RAM port in the cycle it is taken; its
// result waits for a free output register. Input stalls only while a read
// result and a stalled output register are both held. Reset empties the
// FIFO and clears the flags; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo_unit import s2a_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [PTR_W-1:0] write_ptr;
  logic [PTR_W-1:0] read_ptr;
  logic [PTR_W-1:0] write_ptr_inc;
  logic [PTR_W-1:0] read_ptr_inc;
  logic             shift_held;
  logic             caps_on;
  logic             prefix_seen;
  logic             rd_valid;
  logic             rd_hit;
  logic             accept;
  logic             take_scan;
  logic             take_pop;
  logic             fifo_empty;
  logic             fifo_full;
  logic             do_write;
  logic             rd_move;
  xlate_t           xlate;
  fifo_entry_t      rd_entry;

  assign write_ptr_inc = (write_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : write_ptr + 1'b1;
  assign read_ptr_inc  = (read_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : read_ptr + 1'b1;
  assign fifo_empty    = (write_ptr == read_ptr);
  assign fifo_full     = (write_ptr_inc == read_ptr);

  assign rd_move   = rd_valid && (!out_valid || !out_stall);
  assign in_stall  = rd_valid && out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign take_scan = accept && (in_data.req_type == REQ_SCAN);
  assign take_pop  = accept && (in_data.req_type == REQ_POP);
  assign do_write  = take_scan && xlate.put && !fifo_full;

  s2a_xlate u_xlate (
    .scan_byte   (in_data.scan_byte),
    .shift_held  (shift_held),
    .caps_on     (caps_on),
    .prefix_seen (prefix_seen),
    .xlate       (xlate)
  );

  s2a_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (do_write),
    .waddr (write_ptr),
    .wdata (xlate.entry),
    .re    (take_pop),
    .raddr (read_ptr),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr   <= '0;
      read_ptr    <= '0;
      shift_held  <= 1'b0;
      caps_on     <= 1'b0;
      prefix_seen <= 1'b0;
    end else begin
      if (take_scan) begin
        shift_held  <= xlate.shift_held;
        caps_on     <= xlate.caps_on;
        prefix_seen <= xlate.prefix_seen;
      end
      if (do_write) begin
        write_ptr <= write_ptr_inc;
      end
      if (take_pop && !fifo_empty) begin
        read_ptr <= read_ptr_inc;
      end
    end
  end

  // hold the read result until the output register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (take_pop) begin
      rd_valid <= 1'b1;
    end else if (rd_move) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_pop) begin
      rd_hit <= !fifo_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_move) begin
      out_data.char_valid <= rd_hit;
      out_data.is_special <= rd_hit && rd_entry.is_special;
      out_data.char_code  <= rd_hit ? rd_entry.char_code : 8'd0;
    end
  end

endmodule

// File: tb/sv/scancode_to_ascii_fifo_unit_checker.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_unit_checker
// Watches both channels of the unit and keeps its own copy of the keyboard
// flags and the character queue. Every pop taken on the input queues the
// character it should return; every result taken on the output is compared
// field by field with the oldest one. The failure count and the number of
// characters still awaited are handed to the testbench top.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo_unit_checker import s2a_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        errors,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] LAST_MAPPED = 8'h3B;

  localparam logic [0:59][7:0] PLAIN_KEYS = {
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00
  };

  localparam logic [0:59][7:0] SHIFTED_KEYS = {
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00
  };

  localparam logic [7:0] MK_UP    = 8'h48;
  localparam logic [7:0] MK_DOWN  = 8'h50;
  localparam logic [7:0] MK_LEFT  = 8'h4B;
  localparam logic [7:0] MK_RIGHT = 8'h4D;
  localparam logic [7:0] MK_HOME  = 8'h47;
  localparam logic [7:0] MK_END   = 8'h4F;
  localparam logic [7:0] MK_DEL   = 8'h53;
  localparam logic [7:0] MK_PGUP  = 8'h49;
  localparam logic [7:0] MK_PGDN  = 8'h51;

  logic        shift_on;
  logic        caps_set;
  logic        ext_armed;
  fifo_entry_t typed_chars[$];
  out_item_t   awaited_chars[$];
  out_item_t   want;
  int          fails;

  // drop the character when the ring would fill its last slot
  function automatic void queue_char(input fifo_entry_t e);
    if (typed_chars.size() < FIFO_DEPTH - 1) begin
      typed_chars.push_back(e);
    end
  endfunction

  function automatic void take_scancode(input logic [7:0] sc);
    logic [7:0] ch;
    if (sc == SC_PREFIX) begin
      ext_armed = 1'b1;
    end else if (sc[7]) begin
      if (ext_armed) begin
        ext_armed = 1'b0;
      end else if (sc[6:0] == SC_LSHIFT || sc[6:0] == SC_RSHIFT) begin
        shift_on = 1'b0;
      end
    end else if (ext_armed) begin
      ext_armed = 1'b0;
      case (sc)
        MK_UP:    queue_char({1'b1, NAV_UP});
        MK_DOWN:  queue_char({1'b1, NAV_DOWN});
        MK_LEFT:  queue_char({1'b1, NAV_LEFT});
        MK_RIGHT: queue_char({1'b1, NAV_RIGHT});
        MK_HOME:  queue_char({1'b1, NAV_HOME});
        MK_END:   queue_char({1'b1, NAV_END});
        MK_DEL:   queue_char({1'b1, NAV_DEL});
        MK_PGUP:  queue_char({1'b1, NAV_PGUP});
        MK_PGDN:  queue_char({1'b1, NAV_PGDN});
        default: ;
      endcase
    end else if (sc[6:0] == SC_LSHIFT || sc[6:0] == SC_RSHIFT) begin
      shift_on = 1'b1;
    end else if (sc[6:0] == SC_CAPS) begin
      caps_set = ~caps_set;
    end else if (sc <= LAST_MAPPED) begin
      ch = shift_on ? SHIFTED_KEYS[sc] : PLAIN_KEYS[sc];
      if (caps_set && ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z"))) begin
        ch = ch ^ 8'h20;
      end
      if (ch != 8'h00) begin
        queue_char({1'b0, ch});
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      shift_on  = 1'b0;
      caps_set  = 1'b0;
      ext_armed = 1'b0;
      typed_chars.delete();
      awaited_chars.delete();
      fails = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (in_data.req_type == REQ_POP) begin
          if (typed_chars.size() == 0) begin
            awaited_chars.push_back(out_item_t'(0));
          end else begin
            awaited_chars.push_back({1'b1, typed_chars.pop_front()});
          end
        end else begin
          take_scancode(in_data.scan_byte);
        end
      end
      if (out_valid && !out_stall) begin
        if (awaited_chars.size() == 0) begin
          fails++;
          $display("%0t: unexpected: expected none, actual %0b/%0b/%02h",
                   $time, out_data.char_valid, out_data.is_special, out_data.char_code);
        end else begin
          want = awaited_chars.pop_front();
          if (out_data !== want) begin
            fails++;
            $display("%0t: mismatch: expected %0b/%0b/%02h, actual %0b/%0b/%02h",
                     $time, want.char_valid, want.is_special, want.char_code,
                     out_data.char_valid, out_data.is_special, out_data.char_code);
          end
        end
      end
    end
    errors  <= fails;
    pending <= awaited_chars.size();
  end

endmodule

// File: tb/sv/scancode_to_ascii_fifo_unit_tb.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_unit_tb
// Drives scancode and pop transactions into the unit: a short opening run
// through shift, caps lock, prefix and release cases, then random key
// strokes, navigation keys, pops and noise, with two floods that overfill
// the queue and one long receiver hold-off that backs up the input.
// The checker beside the unit predicts and compares; this module gives
// the verdict.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import s2a_pkg::*;

  localparam int OPENING_LEN = 26;
  localparam int ITEM_TARGET = 1950;
  localparam int FLOOD_LEN   = 135;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 2000;

  localparam logic [0:OPENING_LEN-1][8:0] OPENING = {
    {REQ_POP,  8'hFF},
    {REQ_SCAN, 8'h00},
    {REQ_SCAN, 8'hFF},
    {REQ_SCAN, 1'b0, SC_LSHIFT},
    {REQ_SCAN, 8'h02},
    {REQ_SCAN, 8'h10},
    {REQ_SCAN, 1'b1, SC_LSHIFT},
    {REQ_SCAN, 1'b0, SC_CAPS},
    {REQ_SCAN, 8'h1E},
    {REQ_SCAN, 8'h02},
    {REQ_SCAN, 1'b0, SC_RSHIFT},
    {REQ_SCAN, 8'h1E},
    {REQ_SCAN, 1'b1, SC_RSHIFT},
    {REQ_SCAN, SC_PREFIX},
    {REQ_SCAN, 8'h48},
    {REQ_SCAN, SC_PREFIX},
    {REQ_SCAN, SC_PREFIX},
    {REQ_SCAN, 8'h51},
    {REQ_SCAN, SC_PREFIX},
    {REQ_SCAN, 1'b1, SC_LSHIFT},
    {REQ_SCAN, SC_PREFIX},
    {REQ_SCAN, 1'b0, SC_LSHIFT},
    {REQ_SCAN, 8'h10},
    {REQ_SCAN, 8'h7F},
    {REQ_POP,  8'h00},
    {REQ_POP,  8'h5A}
  };

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  bit quiet       = 1'b0;
  bit hold_req    = 1'b0;
  int items_done  = 0;
  int idle_cycles = 0;
  int errors;
  int pending;

  scancode_to_ascii_fifo_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  scancode_to_ascii_fifo_unit_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hold the transaction until taken, then idle now and then
  task automatic offer(input logic req, input logic [7:0] sc, input bit tally);
    in_item_t it;
    it.req_type  = req;
    it.scan_byte = sc;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (tally) begin
      items_done++;
    end
    if (!quiet && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    int         i;
    int         kind;
    int         floods;
    logic [7:0] code;
    logic [6:0] side;
    floods = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (i = 0; i < OPENING_LEN; i++) begin
      offer(OPENING[i][8], OPENING[i][7:0], 1'b1);
    end
    while (items_done < ITEM_TARGET) begin
      if (!hold_req && items_done >= 600) begin
        hold_req <= 1'b1;
      end
      quiet <= (items_done >= 1000 && items_done < 1400);
      kind = $urandom_range(0, 99);
      if ((floods == 0 && items_done >= 300) || (floods == 1 && items_done >= 1500)) begin
        floods++;
        repeat (FLOOD_LEN) offer(REQ_SCAN, 8'($urandom_range(8'h10, 8'h19)), 1'b1);
        repeat (FLOOD_LEN + 5) offer(REQ_POP, 8'($urandom_range(0, 255)), 1'b1);
      end else if (kind < 35) begin
        code = 8'($urandom_range(8'h01, 8'h39));
        offer(REQ_SCAN, code, 1'b1);
        offer(REQ_SCAN, code | 8'h80, 1'b1);
      end else if (kind < 45) begin
        code = 8'($urandom_range(8'h01, 8'h39));
        side = ($urandom_range(0, 1) == 0) ? SC_LSHIFT : SC_RSHIFT;
        offer(REQ_SCAN, {1'b0, side}, 1'b1);
        offer(REQ_SCAN, code, 1'b1);
        offer(REQ_SCAN, code | 8'h80, 1'b1);
        offer(REQ_SCAN, {1'b1, side}, 1'b1);
      end else if (kind < 55) begin
        code = 8'($urandom_range(8'h47, 8'h53));
        offer(REQ_SCAN, SC_PREFIX, 1'b1);
        offer(REQ_SCAN, code, 1'b1);
        offer(REQ_SCAN, SC_PREFIX, 1'b1);
        offer(REQ_SCAN, code | 8'h80, 1'b1);
      end else if (kind < 58) begin
        offer(REQ_SCAN, {1'b0, SC_CAPS}, 1'b1);
        offer(REQ_SCAN, {1'b1, SC_CAPS}, 1'b1);
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 2)) offer(REQ_POP, 8'($urandom_range(0, 255)), 1'b1);
      end else begin
        offer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b1);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 8);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: files.f
rtl/s2a_pkg.sv
rtl/s2a_ram.sv
rtl/s2a_xlate.sv
rtl/scancode_to_ascii_fifo_unit.sv
tb/sv/scancode_to_ascii_fifo_unit_checker.sv
tb/sv/scancode_to_ascii_fifo_unit_tb.sv
